@@ design/leb_pkg.sv @@
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the LEB128 / zigzag varint encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package leb_pkg;

  localparam int unsigned DigitW   = 7;
  localparam int unsigned GroupCnt = 19;
  localparam int unsigned ValW     = DigitW * GroupCnt;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_U64  = 3'd0,
    MODE_U128 = 3'd1,
    MODE_ZZ   = 3'd2,
    MODE_TAG  = 3'd3,
    MODE_BOOL = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

`default_nettype wire

@@ design/varint_leb128_zigzag_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// varint_leb128_zigzag_encoder_unit
// Shortest-form unsigned LEB128 encoder with unsigned, zigzag, tag and boolean
// modes; the value is shifted out one 7-bit digit per cycle while the output is ready.
// Latency: first byte is valid the cycle after the input transfer.
// Throughput: one output byte per cycle while m_axis_tready_i is high; an item
// gives 1 to 19 bytes from the 7-bit digit shift register, and the next item
// is taken in the cycle its last byte transfers. Modes 5 to 7 give no output.
// Reset: asynchronous active-low, returns the controller to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_leb128_zigzag_encoder_unit
  import leb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [2:0] mode, [66:3] value_low, [130:67] value_high, [135:131] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [7:0] out_byte
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o,
  // [0] rejected
  output logic                     m_axis_tuser_o
);

  state_e                state_q, state_d;
  logic [ValW-1:0]       data_q, data_d;
  logic [GroupCnt-1:0]   nz_q, nz_d;
  logic                  rej_q, rej_d;

  mode_e                 in_mode;
  logic [HalfW-1:0]      in_lo;
  logic [HalfW-1:0]      in_hi;
  logic [ValW-1:0]       load_val;
  logic [GroupCnt-1:0]   load_nz;
  logic                  load_rej;
  logic                  load_ok;
  logic                  lo_nz;
  logic                  more;
  logic                  s_xfer;
  logic                  m_xfer;

  assign in_mode = mode_e'(s_axis_tdata_i[ModeW-1:0]);
  assign in_lo   = s_axis_tdata_i[ModeW +: HalfW];
  assign in_hi   = s_axis_tdata_i[ModeW+HalfW +: HalfW];
  assign lo_nz   = |in_lo;

  always_comb begin
    load_val = '0;
    load_rej = 1'b0;
    load_ok  = 1'b1;
    unique case (in_mode)
      MODE_U64: begin
        load_val[HalfW-1:0] = in_lo;
      end
      MODE_U128: begin
        load_val[2*HalfW-1:0] = {in_hi, in_lo};
      end
      MODE_ZZ: begin
        load_val[HalfW-1:0] = {in_lo[HalfW-2:0], 1'b0} ^ {HalfW{in_lo[HalfW-1]}};
      end
      MODE_TAG: begin
        load_val[HalfW-1:0] = in_lo;
        load_rej            = ~lo_nz;
      end
      MODE_BOOL: begin
        load_val[0] = lo_nz;
      end
      default: begin
        load_ok = 1'b0;
      end
    endcase
  end

  // per-digit nonzero marks, consumed one per emitted byte
  always_comb begin
    for (int g = 0; g < GroupCnt; g++) begin
      load_nz[g] = |load_val[g*DigitW +: DigitW];
    end
  end

  assign more            = |nz_q[GroupCnt-1:1];
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_axis_tdata_o  = {more, data_q[DigitW-1:0]};
  assign m_axis_tlast_o  = ~more;
  assign m_axis_tuser_o  = rej_q;

  assign m_xfer          = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) | (m_xfer & ~more);
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    data_d  = data_q;
    nz_d    = nz_q;
    rej_d   = rej_q;
    if (m_xfer) begin
      data_d = {{DigitW{1'b0}}, data_q[ValW-1:DigitW]};
      nz_d   = {1'b0, nz_q[GroupCnt-1:1]};
      if (!more) begin
        state_d = ST_IDLE;
      end
    end
    if (s_xfer) begin
      data_d  = load_val;
      nz_d    = load_nz;
      rej_d   = load_rej;
      state_d = load_ok ? ST_EMIT : ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    nz_q   <= nz_d;
    rej_q  <= rej_d;
  end

  a_rej_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("rejected transfer is not a single zero byte");

  a_cont_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OutDataW-1] == !m_axis_tlast_o))
    else $error("continuation flag disagrees with tlast");

  a_take_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && state_q == ST_EMIT) |-> (m_xfer && m_axis_tlast_o))
    else $error("input taken while bytes still pending");

  a_last_idles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_xfer && m_axis_tlast_o && !s_axis_tvalid_i) |=> (state_q == ST_IDLE))
    else $error("encoder still busy after final byte");

endmodule

`default_nettype wire

@@ tb/sv/varint_leb128_zigzag_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// varint_leb128_zigzag_encoder_unit_tb
// Self-checking bench for the LEB128 / zigzag varint encoder. A directed table
// covers the value extremes, every mode, tag zero, boolean truth, the ignored
// high half and the undefined modes. Constrained-free random items follow,
// with value widths spread so every byte count from 1 to 19 turns up. Each
// output transfer is checked field by field against the directed row's expected
// byte or a behavioural encoder, with random idle bursts on both streams and drain-to-empty pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_leb128_zigzag_encoder_unit_tb
  import leb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ModeW-1:0] MODE_UNDEF5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_UNDEF6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNDEF7 = 3'd7;
  localparam logic [HalfW-1:0] ALL1 = '1;
  localparam logic [HalfW-1:0] MSB  = 64'h8000_0000_0000_0000;
  localparam int unsigned      RandItems = 450;
  localparam int unsigned      CalmFrom  = 390;

  typedef struct packed {
    logic [OutDataW-1:0] code;
    logic                fin;
    logic                rej;
  } enc_octet_t;

  typedef struct {
    logic [ModeW-1:0]    m;
    logic [HalfW-1:0]    lo;
    logic [HalfW-1:0]    hi;
    bit                  fixed;
    logic [OutDataW-1:0] want_code;
    logic                want_rej;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tuser_o;

  enc_octet_t pending_octets[$];
  int         n_errs = 0;
  int         n_octets = 0;
  int         n_rejects = 0;
  int         mode_cnt[8];
  int         idle_pct = 0;
  bit         calm = 1'b0;

  stim_row_t dir_rows[25] = '{
    '{MODE_U64,    64'd0,      64'd0, 1'b1, 8'h00, 1'b0},
    '{MODE_U64,    64'h7F,     64'd0, 1'b1, 8'h7F, 1'b0},
    '{MODE_U64,    64'h80,     64'd0, 1'b0, 8'h00, 1'b0},
    '{MODE_U64,    ALL1,       64'd0, 1'b0, 8'h00, 1'b0},
    '{MODE_U64,    64'd1,      ALL1,  1'b1, 8'h01, 1'b0},
    '{MODE_U128,   64'd0,      64'd0, 1'b1, 8'h00, 1'b0},
    '{MODE_U128,   ALL1,       ALL1,  1'b0, 8'h00, 1'b0},
    '{MODE_U128,   64'd0,      64'd1, 1'b0, 8'h00, 1'b0},
    '{MODE_U128,   64'd0,      MSB,   1'b0, 8'h00, 1'b0},
    '{MODE_ZZ,     64'd0,      64'd0, 1'b1, 8'h00, 1'b0},
    '{MODE_ZZ,     ALL1,       ALL1,  1'b1, 8'h01, 1'b0},
    '{MODE_ZZ,     64'd1,      64'd0, 1'b1, 8'h02, 1'b0},
    '{MODE_ZZ,     -64'sd64,   64'd0, 1'b1, 8'h7F, 1'b0},
    '{MODE_ZZ,     ~MSB,       64'd0, 1'b0, 8'h00, 1'b0},
    '{MODE_ZZ,     MSB,        64'd0, 1'b0, 8'h00, 1'b0},
    '{MODE_TAG,    64'd0,      64'd0, 1'b1, 8'h00, 1'b1},
    '{MODE_TAG,    64'd0,      ALL1,  1'b1, 8'h00, 1'b1},
    '{MODE_TAG,    64'd1,      64'd0, 1'b1, 8'h01, 1'b0},
    '{MODE_TAG,    ALL1,       ALL1,  1'b0, 8'h00, 1'b0},
    '{MODE_BOOL,   64'd0,      ALL1,  1'b1, 8'h00, 1'b0},
    '{MODE_BOOL,   64'd1,      64'd0, 1'b1, 8'h01, 1'b0},
    '{MODE_BOOL,   MSB,        64'd0, 1'b1, 8'h01, 1'b0},
    '{MODE_UNDEF5, 64'd0,      64'd0, 1'b0, 8'h00, 1'b0},
    '{MODE_UNDEF6, 64'd5,      64'd5, 1'b0, 8'h00, 1'b0},
    '{MODE_UNDEF7, ALL1,       ALL1,  1'b0, 8'h00, 1'b0}
  };

  varint_leb128_zigzag_encoder_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Queue the bytes one item should produce, least significant group first.
  function automatic void encode_varint(input logic [ModeW-1:0] m,
                                        input logic [HalfW-1:0] lo,
                                        input logic [HalfW-1:0] hi);
    logic [2*HalfW-1:0] acc;
    logic               more;
    int                 n;
    acc = '0;
    case (mode_e'(m))
      MODE_U64:  acc = {64'd0, lo};
      MODE_U128: acc = {hi, lo};
      MODE_ZZ:   acc = {64'd0, (lo << 1) ^ {HalfW{lo[HalfW-1]}}};
      MODE_TAG: begin
        if (lo == '0) begin
          pending_octets.push_back('{8'h00, 1'b1, 1'b1});
          return;
        end
        acc = {64'd0, lo};
      end
      MODE_BOOL: begin
        pending_octets.push_back('{{7'd0, |lo}, 1'b1, 1'b0});
        return;
      end
      default: return;
    endcase
    n = 0;
    do begin
      more = (acc >> DigitW) != '0;
      pending_octets.push_back('{{more, acc[DigitW-1:0]}, ~more, 1'b0});
      acc = acc >> DigitW;
      n++;
    end while (more && n < GroupCnt);
  endfunction

  // Leaves tvalid high after the transfer; the caller lowers it when done.
  task automatic send_item(input logic [ModeW-1:0] m, input logic [HalfW-1:0] lo,
                           input logic [HalfW-1:0] hi, input bit fixed,
                           input enc_octet_t want);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, hi, lo, m};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    mode_cnt[m]++;
    if (fixed) pending_octets.push_back(want);
    else encode_varint(m, lo, hi);
  endtask

  task automatic drain_all();
    s_axis_tvalid_i <= 1'b0;
    wait (pending_octets.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic logic [HalfW-1:0] pick_word();
    logic [HalfW-1:0] w;
    int               wid;
    w   = {$urandom, $urandom};
    wid = $urandom_range(1, 64);
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = ALL1;
      2, 3, 4, 5: if (wid < 64) w &= (64'd1 << wid) - 64'd1;
      6: if (wid < 64) w = -(w & ((64'd1 << wid) - 64'd1));
      default: ;
    endcase
    return w;
  endfunction

  // Output stall pattern.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(1, 100) <= idle_pct / 3) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    enc_octet_t exp_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_octets++;
      if (m_axis_tuser_o) n_rejects++;
      if (pending_octets.size() == 0) begin
        n_errs++;
        $display("%0t: unexpected transfer byte %h last %b rej %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        exp_o = pending_octets.pop_front();
        if (m_axis_tdata_o !== exp_o.code) begin
          n_errs++;
          $display("%0t: byte expected %h actual %h", $time, exp_o.code, m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== exp_o.fin) begin
          n_errs++;
          $display("%0t: tlast expected %b actual %b", $time, exp_o.fin, m_axis_tlast_o);
        end
        if (m_axis_tuser_o !== exp_o.rej) begin
          n_errs++;
          $display("%0t: rejected expected %b actual %b", $time, exp_o.rej, m_axis_tuser_o);
        end
      end
    end
  end

  initial begin
    logic [ModeW-1:0] m;
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    int               n_rand;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].m, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].fixed,
                '{dir_rows[i].want_code, 1'b1, dir_rows[i].want_rej});
    end
    drain_all();

    n_rand = 0;
    while (n_rand < RandItems) begin
      if (n_rand % 75 == 0) idle_pct = ((n_rand / 75) % 3 == 1) ? 0 : $urandom_range(10, 50);
      if (n_rand >= CalmFrom) calm = 1'b1;
      if (n_rand == RandItems / 2) drain_all();
      if ($urandom_range(0, 39) == 0) m = ModeW'($urandom_range(5, 7));
      else m = ModeW'($urandom_range(0, 4));
      lo = pick_word();
      hi = pick_word();
      send_item(m, lo, hi, 1'b0, '0);
      if (m <= MODE_BOOL) n_rand++;
    end
    s_axis_tvalid_i <= 1'b0;

    for (int c = 0; c < 2000 && pending_octets.size() != 0; c++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_octets.size() != 0) begin
      n_errs += pending_octets.size();
      $display("%0t: %0d expected bytes never arrived", $time, pending_octets.size());
    end

    $display("covered items u64 %0d u128 %0d zigzag %0d tag %0d bool %0d undefined %0d",
             mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], mode_cnt[4],
             mode_cnt[5] + mode_cnt[6] + mode_cnt[7]);
    $display("checked %0d output bytes, %0d tag rejections, %0d mismatches",
             n_octets, n_rejects, n_errs);
    if (n_errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
